// ----- rtl/v4alu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_pkg: shared types and helpers of the vector unit
// Operation codes, stage sideband structs and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package v4alu_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   typedef enum logic [2:0] {
      FUNC_ADD       = 3'd0,
      FUNC_SUB       = 3'd1,
      FUNC_SCALE     = 3'd2,
      FUNC_DIVIDE    = 3'd3,
      FUNC_DOT       = 3'd4,
      FUNC_CROSS     = 3'd5,
      FUNC_LENGTH    = 3'd6,
      FUNC_NORMALIZE = 3'd7
   } func_type;

   typedef logic [3:0][31:0] vec_type;

   // sideband carried alongside the square root pipeline
   typedef struct packed {
      func_type    func;
      vec_type     a;
      logic [31:0] scalar;
      vec_type     vec;
      logic [31:0] rs_dot;
   } sq_side_type;

   // sideband carried alongside the divider pipeline
   typedef struct packed {
      func_type    func;
      logic        flag;
      logic [3:0]  neg;
      vec_type     vec;
      logic [31:0] rs;
   } dv_side_type;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] res;
      if (v > SAT_HI) begin
         res = 32'h7fff_ffff;
      end else if (v < SAT_LO) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/vec4_vector_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vec4_vector_alu: four-component Q16.16 vector unit
// Add, sub, scale, divide, dot, cross, length and normalize, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one request word per cycle while the response side keeps up
// and returns one response word per request, in order. Every operation runs
// the same path: input register, multiply (eight 32x32 multipliers), two
// accumulate and round stages, a 16-stage square root (two root bits per
// stage), a divisor prepare stage, an 18-stage four-lane divider (overflow
// check plus two quotient bits per stage) and the output register. The
// latency is set by the square root and divider depth; throughput is one
// word per cycle while no response is held. A stalled response freezes the
// whole pipe, so req_ready follows rsp_ready combinationally while a
// response is held. Results round as described per operation and saturate to
// the signed 32-bit range; divide by zero and normalize of a zero vector raise
// rsp_div_zero and return a zero vector.
module vec4_vector_alu
   import v4alu_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_a_w,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_b_w,
   input  logic signed [31:0] req_scalar,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_r_x,
   output logic signed [31:0] rsp_r_y,
   output logic signed [31:0] rsp_r_z,
   output logic signed [31:0] rsp_r_w,
   output logic signed [31:0] rsp_r_scalar,
   output logic               rsp_div_zero
);

   localparam int NW = FRAC_BITS + 34;
   // round half up before the fraction shift
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   logic en;

   // input stage
   logic        in_valid_ff;
   func_type    in_func_ff;
   vec_type     in_a_ff;
   vec_type     in_b_ff;
   logic [31:0] in_s_ff;

   // multiply stage
   logic               mul_valid_ff;
   func_type           mul_func_ff;
   vec_type            mul_a_ff;
   logic [31:0]        mul_s_ff;
   vec_type            mul_vec_ff;
   vec_type            mul_vec_in;
   logic signed [63:0] mul_p_ff [4];
   logic signed [63:0] mul_p_in [4];
   logic signed [63:0] mul_q_ff [4];
   logic signed [63:0] mul_q_in [4];

   // accumulate stage
   logic               acc_valid_ff;
   func_type           acc_func_ff;
   vec_type            acc_a_ff;
   logic [31:0]        acc_s_ff;
   vec_type            acc_vec_ff;
   logic signed [65:0] acc_t_ff [4];
   logic signed [65:0] acc_t_in [4];

   // round stage
   logic        fin_valid_ff;
   logic [63:0] fin_rad_ff;
   logic [63:0] fin_rad_in;
   sq_side_type fin_side_ff;
   sq_side_type fin_side_in;

   // square root outputs
   logic        sq_valid;
   logic [31:0] sq_root;
   logic [33:0] sq_rem;
   sq_side_type sq_side;

   // divisor prepare stage
   logic               dvp_valid_ff;
   logic [3:0][NW-1:0] dvp_num_ff;
   logic [3:0][NW-1:0] dvp_num_in;
   logic [32:0]        dvp_den_ff;
   logic [32:0]        dvp_den_in;
   dv_side_type        dvp_side_ff;
   dv_side_type        dvp_side_in;

   // divider outputs
   logic               dv_valid;
   logic [3:0][33:0]   dv_quo;
   logic [3:0]         dv_ovf;
   dv_side_type        dv_side;

   // response register
   logic        rsp_valid_ff;
   vec_type     rsp_vec_ff;
   vec_type     rsp_vec_in;
   logic [31:0] rsp_rs_ff;
   logic        rsp_flag_ff;

   // advance the whole pipe unless a response word is held
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         acc_valid_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
         dvp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff  <= req_valid;
         mul_valid_ff <= in_valid_ff;
         acc_valid_ff <= mul_valid_ff;
         fin_valid_ff <= acc_valid_ff;
         dvp_valid_ff <= sq_valid;
         rsp_valid_ff <= dv_valid;
      end
   end

   // capture request word
   always_ff @(posedge clock) begin
      if (en) begin
         in_func_ff <= func_type'(req_func);
         in_a_ff    <= {req_a_w, req_a_z, req_a_y, req_a_x};
         in_b_ff    <= {req_b_w, req_b_z, req_b_y, req_b_x};
         in_s_ff    <= req_scalar;
      end
   end

   // select multiplier operands and form add/sub results
   always_comb begin : p_mul
      logic signed [31:0] pa [4];
      logic signed [31:0] pb [4];
      logic signed [31:0] qa [4];
      logic signed [31:0] qb [4];
      logic signed [31:0] sa [4];
      logic signed [31:0] sb [4];
      logic signed [32:0] s33;
      for (int i = 0; i < 4; i++) begin
         sa[i] = $signed(in_a_ff[i]);
         sb[i] = $signed(in_b_ff[i]);
         pa[i] = '0;
         pb[i] = '0;
         qa[i] = '0;
         qb[i] = '0;
      end
      case (in_func_ff)
         FUNC_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               pa[i] = sa[i];
               pb[i] = $signed(in_s_ff);
            end
         end
         FUNC_DOT: begin
            for (int i = 0; i < 4; i++) begin
               pa[i] = sa[i];
               pb[i] = sb[i];
            end
         end
         FUNC_CROSS: begin
            pa[0] = sa[1]; pb[0] = sb[2]; qa[0] = sb[1]; qb[0] = sa[2];
            pa[1] = sb[0]; pb[1] = sa[2]; qa[1] = sa[0]; qb[1] = sb[2];
            pa[2] = sa[0]; pb[2] = sb[1]; qa[2] = sa[1]; qb[2] = sb[0];
         end
         FUNC_LENGTH, FUNC_NORMALIZE: begin
            for (int i = 0; i < 4; i++) begin
               pa[i] = sa[i];
               pb[i] = sa[i];
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         mul_p_in[i] = pa[i] * pb[i];
         mul_q_in[i] = qa[i] * qb[i];
         if (in_func_ff == FUNC_ADD) begin
            s33 = 33'(sa[i]) + 33'(sb[i]);
         end else begin
            s33 = 33'(sa[i]) - 33'(sb[i]);
         end
         if (in_func_ff == FUNC_ADD || in_func_ff == FUNC_SUB) begin
            mul_vec_in[i] = sat32(66'(s33));
         end else begin
            mul_vec_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_func_ff <= in_func_ff;
         mul_a_ff    <= in_a_ff;
         mul_s_ff    <= in_s_ff;
         mul_vec_ff  <= mul_vec_in;
         for (int i = 0; i < 4; i++) begin
            mul_p_ff[i] <= mul_p_in[i];
            mul_q_ff[i] <= mul_q_in[i];
         end
      end
   end

   // cross differences, pairwise sums for dot and sum of squares, else the products
   always_comb begin : p_acc
      for (int i = 0; i < 4; i++) begin
         case (mul_func_ff)
            FUNC_CROSS: begin
               acc_t_in[i] = 66'(mul_p_ff[i]) - 66'(mul_q_ff[i]);
            end
            FUNC_DOT, FUNC_LENGTH, FUNC_NORMALIZE: begin
               if (i < 2) begin
                  acc_t_in[i] = 66'(mul_p_ff[2*i]) + 66'(mul_p_ff[2*i+1]);
               end else begin
                  acc_t_in[i] = '0;
               end
            end
            default: begin
               acc_t_in[i] = 66'(mul_p_ff[i]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_func_ff <= mul_func_ff;
         acc_a_ff    <= mul_a_ff;
         acc_s_ff    <= mul_s_ff;
         acc_vec_ff  <= mul_vec_ff;
         for (int i = 0; i < 4; i++) begin
            acc_t_ff[i] <= acc_t_in[i];
         end
      end
   end

   // round and saturate product results; clamp the sum of squares to 64 bits
   always_comb begin : p_fin
      logic signed [65:0] sum;
      sum = acc_t_ff[0] + acc_t_ff[1];
      fin_rad_in         = sum[64] ? '1 : sum[63:0];
      fin_side_in.func   = acc_func_ff;
      fin_side_in.a      = acc_a_ff;
      fin_side_in.scalar = acc_s_ff;
      fin_side_in.rs_dot = (acc_func_ff == FUNC_DOT) ?
                           sat32((sum + HALF) >>> FRAC_BITS) : '0;
      for (int i = 0; i < 4; i++) begin
         case (acc_func_ff)
            FUNC_ADD, FUNC_SUB: begin
               fin_side_in.vec[i] = acc_vec_ff[i];
            end
            FUNC_SCALE, FUNC_CROSS: begin
               fin_side_in.vec[i] = sat32((acc_t_ff[i] + HALF) >>> FRAC_BITS);
            end
            default: begin
               fin_side_in.vec[i] = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_rad_ff  <= fin_rad_in;
         fin_side_ff <= fin_side_in;
      end
   end

   v4alu_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (fin_valid_ff),
      .up_rad   (fin_rad_ff),
      .up_side  (fin_side_ff),
      .dn_valid (sq_valid),
      .dn_root  (sq_root),
      .dn_rem   (sq_rem),
      .dn_side  (sq_side)
   );

   // round the root, pick the divisor and build unsigned numerators
   always_comb begin : p_prep
      logic [32:0] len33;
      logic [31:0] rs_len;
      logic [31:0] d;
      logic [31:0] ud;
      logic [31:0] ua;
      logic        div_op;
      len33  = {1'b0, sq_root} + 33'(sq_rem > {2'b00, sq_root});
      rs_len = (len33 > 33'h0_7fff_ffff) ? 32'h7fff_ffff : len33[31:0];
      div_op = sq_side.func == FUNC_DIVIDE;
      d      = div_op ? sq_side.scalar : rs_len;
      ud     = d[31] ? (~d + 32'd1) : d;
      dvp_den_in = {ud, 1'b0};
      dvp_side_in.func = sq_side.func;
      dvp_side_in.vec  = sq_side.vec;
      dvp_side_in.flag = (div_op && sq_side.scalar == 32'd0) ||
                         (sq_side.func == FUNC_NORMALIZE && rs_len == 32'd0);
      case (sq_side.func)
         FUNC_DOT: begin
            dvp_side_in.rs = sq_side.rs_dot;
         end
         FUNC_LENGTH, FUNC_NORMALIZE: begin
            dvp_side_in.rs = rs_len;
         end
         default: begin
            dvp_side_in.rs = '0;
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         ua = sq_side.a[i][31] ? (~sq_side.a[i] + 32'd1) : sq_side.a[i];
         dvp_side_in.neg[i] = sq_side.a[i][31] ^ (div_op && sq_side.scalar[31]);
         dvp_num_in[i] = (NW'(ua) << (FRAC_BITS + 1)) + NW'(ud);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dvp_num_ff  <= dvp_num_in;
         dvp_den_ff  <= dvp_den_in;
         dvp_side_ff <= dvp_side_in;
      end
   end

   v4alu_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (dvp_valid_ff),
      .up_num   (dvp_num_ff),
      .up_den   (dvp_den_ff),
      .up_side  (dvp_side_ff),
      .dn_valid (dv_valid),
      .dn_quo   (dv_quo),
      .dn_ovf   (dv_ovf),
      .dn_side  (dv_side)
   );

   // apply sign, saturate quotients and merge with the other results
   always_comb begin : p_out
      logic [33:0] nq;
      logic [31:0] qs;
      for (int i = 0; i < 4; i++) begin
         nq = ~dv_quo[i] + 34'd1;
         if (dv_side.neg[i]) begin
            qs = (dv_ovf[i] || dv_quo[i] > 34'h0_8000_0000) ? 32'h8000_0000 : nq[31:0];
         end else begin
            qs = (dv_ovf[i] || dv_quo[i] > 34'h0_7fff_ffff) ? 32'h7fff_ffff :
                 dv_quo[i][31:0];
         end
         case (dv_side.func)
            FUNC_DIVIDE, FUNC_NORMALIZE: begin
               rsp_vec_in[i] = dv_side.flag ? '0 : qs;
            end
            default: begin
               rsp_vec_in[i] = dv_side.vec[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_vec_ff  <= rsp_vec_in;
         rsp_rs_ff   <= dv_side.rs;
         rsp_flag_ff <= dv_side.flag;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_r_x      = rsp_vec_ff[0];
   assign rsp_r_y      = rsp_vec_ff[1];
   assign rsp_r_z      = rsp_vec_ff[2];
   assign rsp_r_w      = rsp_vec_ff[3];
   assign rsp_r_scalar = rsp_rs_ff;
   assign rsp_div_zero = rsp_flag_ff;

`ifndef SYNTHESIS
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |->
         rsp_r_x == 0 && rsp_r_y == 0 && rsp_r_z == 0 && rsp_r_w == 0)
      else $error("division by zero gave a nonzero vector");

   a_zero_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_r_scalar == 0)
      else $error("division by zero gave a nonzero scalar");

   a_flag_func: assert property (@(posedge clock) disable iff (reset)
      dvp_valid_ff && dvp_side_ff.flag |->
         dvp_side_ff.func == FUNC_DIVIDE || dvp_side_ff.func == FUNC_NORMALIZE)
      else $error("zero divisor flag on an operation without division");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sq_valid |-> sq_rem <= {1'b0, sq_root, 1'b0})
      else $error("square root remainder exceeds twice the root");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dvp_valid_ff) && $stable(fin_valid_ff))
      else $error("pipeline moved during a response stall");
`endif

endmodule
`default_nettype wire

// ----- rtl/v4alu_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_sqrt: pipelined integer square root
// Sixteen stages, two radicand bit pairs each; gives floor root and remainder.
// ----------------------------------------------------------------------------
module v4alu_sqrt
   import v4alu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        up_valid,
   input  logic [63:0] up_rad,
   input  sq_side_type up_side,
   output logic        dn_valid,
   output logic [31:0] dn_root,
   output logic [33:0] dn_rem,
   output sq_side_type dn_side
);

   localparam int STAGES = 16;
   localparam int STEPS  = 2;

   logic [STAGES-1:0] valid_ff;
   logic [33:0]       rem_ff  [STAGES];
   logic [33:0]       rem_in  [STAGES];
   logic [31:0]       root_ff [STAGES];
   logic [31:0]       root_in [STAGES];
   logic [63:0]       rad_ff  [STAGES];
   logic [63:0]       rad_in  [STAGES];
   sq_side_type       side_ff [STAGES];

   always_comb begin : p_step
      logic [35:0] t;
      logic [35:0] trial;
      logic [33:0] r;
      logic [31:0] q;
      logic [63:0] d;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            r = '0;
            q = '0;
            d = up_rad;
         end else begin
            r = rem_ff[k-1];
            q = root_ff[k-1];
            d = rad_ff[k-1];
         end
         for (int i = 0; i < STEPS; i++) begin
            t     = {r, d[63:62]};
            trial = {2'b00, q, 2'b01};
            if (t >= trial) begin
               r = 34'(t - trial);
               q = {q[30:0], 1'b1};
            end else begin
               r = t[33:0];
               q = {q[30:0], 1'b0};
            end
            d = {d[61:0], 2'b00};
         end
         rem_in[k]  = r;
         root_in[k] = q;
         rad_in[k]  = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], up_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= (k == 0) ? up_side : side_ff[k-1];
         end
      end
   end

   assign dn_valid = valid_ff[STAGES-1];
   assign dn_root  = root_ff[STAGES-1];
   assign dn_rem   = rem_ff[STAGES-1];
   assign dn_side  = side_ff[STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/v4alu_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_div: four-lane pipelined restoring divider
// Overflow check stage, then two quotient bits per stage over a shared divisor.
// ----------------------------------------------------------------------------
module v4alu_div
   import v4alu_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         up_valid,
   input  logic [3:0][FRAC_BITS+33:0]   up_num,
   input  logic [32:0]                  up_den,
   input  dv_side_type                  up_side,
   output logic                         dn_valid,
   output logic [3:0][33:0]             dn_quo,
   output logic [3:0]                   dn_ovf,
   output dv_side_type                  dn_side
);

   localparam int NW     = FRAC_BITS + 34;
   localparam int QB     = 34;
   localparam int DW     = 33;
   localparam int STEPS  = 2;
   localparam int DEPTH  = QB / STEPS + 1;

   logic [DEPTH-1:0]      valid_ff;
   logic [DW-1:0]         den_ff  [DEPTH];
   logic [3:0]            ovf_ff  [DEPTH];
   logic [3:0]            ovf_in;
   dv_side_type           side_ff [DEPTH];
   logic [3:0][DW-1:0]    rem_ff  [DEPTH];
   logic [3:0][DW-1:0]    rem_in  [DEPTH];
   logic [3:0][QB-1:0]    low_ff  [DEPTH];
   logic [3:0][QB-1:0]    low_in  [DEPTH];
   logic [3:0][QB-1:0]    quo_ff  [DEPTH];
   logic [3:0][QB-1:0]    quo_in  [DEPTH];

   always_comb begin : p_step
      logic [NW-1:0] hi;
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QB-1:0] lo;
      logic [QB-1:0] q;
      for (int l = 0; l < 4; l++) begin
         // quotient of 2^QB or more saturates anyway
         hi           = up_num[l] >> QB;
         ovf_in[l]    = hi >= NW'(up_den);
         rem_in[0][l] = hi[DW-1:0];
         low_in[0][l] = up_num[l][QB-1:0];
         quo_in[0][l] = '0;
      end
      for (int k = 1; k < DEPTH; k++) begin
         for (int l = 0; l < 4; l++) begin
            r  = rem_ff[k-1][l];
            lo = low_ff[k-1][l];
            q  = quo_ff[k-1][l];
            for (int i = 0; i < STEPS; i++) begin
               t = {r, lo[QB-1]};
               if (t >= {1'b0, den_ff[k-1]}) begin
                  r = DW'(t - {1'b0, den_ff[k-1]});
                  q = {q[QB-2:0], 1'b1};
               end else begin
                  r = t[DW-1:0];
                  q = {q[QB-2:0], 1'b0};
               end
               lo = {lo[QB-2:0], 1'b0};
            end
            rem_in[k][l] = r;
            low_in[k][l] = lo;
            quo_in[k][l] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], up_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DEPTH; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            if (k == 0) begin
               den_ff[k]  <= up_den;
               ovf_ff[k]  <= ovf_in;
               side_ff[k] <= up_side;
            end else begin
               den_ff[k]  <= den_ff[k-1];
               ovf_ff[k]  <= ovf_ff[k-1];
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   assign dn_valid = valid_ff[DEPTH-1];
   assign dn_quo   = quo_ff[DEPTH-1];
   assign dn_ovf   = ovf_ff[DEPTH-1];
   assign dn_side  = side_ff[DEPTH-1];

endmodule
`default_nettype wire
